### rtl/amdfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_pkg
// Shared constants and types of the adjacency matrix depth-first order block.
// ----------------------------------------------------------------------------
package amdfs_pkg;

   // Largest graph the block holds.
   localparam int MAX_VERTICES = 64;

   // Widths fixed by the request and response fields.
   localparam int VERTEX_W = 6;
   localparam int COUNT_W  = 7;

   // One adjacency row covers every vertex index the fields can name.
   localparam int ROW_W = 1 << VERTEX_W;

   // Address width of the adjacency and path stack memories.
   localparam int ADDR_W = $clog2(MAX_VERTICES);

   // Lowest-bit search works on groups of eight candidates.
   localparam int GROUP_W    = 8;
   localparam int GRP_IDX_W  = $clog2(GROUP_W);
   localparam int NUM_GROUPS = ROW_W / GROUP_W;
   localparam int GRP_SEL_W  = VERTEX_W - GRP_IDX_W;

   // Request operation codes.
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_TRAVERSE = 1'b1;

   // Result of the lowest-bit search.
   typedef struct packed {
      logic                found;
      logic [VERTEX_W-1:0] index;
   } lowbit_type;

endpackage
`default_nettype wire

### rtl/amdfs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_req_if
// Request channel: add-edge and traverse requests with valid/ready handshake.
// ----------------------------------------------------------------------------
interface amdfs_req_if
   import amdfs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [VERTEX_W-1:0] from_vertex;
   logic [VERTEX_W-1:0] to_vertex;

   modport source (output valid, output operation, output from_vertex,
                   output to_vertex, input ready);
   modport sink   (input valid, input operation, input from_vertex,
                   input to_vertex, output ready);
endinterface
`default_nettype wire

### rtl/amdfs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_rsp_if
// Response channel: visited vertices in depth-first order.
// ----------------------------------------------------------------------------
interface amdfs_rsp_if
   import amdfs_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] visited_vertex;
   logic                last_in_order;

   modport source (output valid, output visited_vertex, output last_in_order,
                   input ready);
   modport sink   (input valid, input visited_vertex, input last_in_order,
                   output ready);
endinterface
`default_nettype wire

### rtl/amdfs_lowbit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_lowbit
// Two-stage lowest set bit search over one candidate row.
// ----------------------------------------------------------------------------
module amdfs_lowbit
   import amdfs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             load,
   input  wire logic [ROW_W-1:0] cand,
   output lowbit_type            result
);

   logic [NUM_GROUPS-1:0] grp_any_ff;
   logic [NUM_GROUPS-1:0] grp_any_in;
   logic [GRP_IDX_W-1:0]  grp_idx_ff [NUM_GROUPS];
   logic [GRP_IDX_W-1:0]  grp_idx_in [NUM_GROUPS];

   // First stage: per group, whether any bit is set and the lowest one.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |cand[g*GROUP_W +: GROUP_W];
         grp_idx_in[g] = '0;
         for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (cand[g*GROUP_W + j]) begin
               grp_idx_in[g] = GRP_IDX_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   // Second stage: the lowest group that has a candidate wins.
   always_comb begin
      result.found = |grp_any_ff;
      result.index = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            result.index = {GRP_SEL_W'(g), grp_idx_ff[g]};
         end
      end
   end

endmodule
`default_nettype wire

### rtl/adjacency_matrix_dfs_order.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_order
// Directed graph in an adjacency bit matrix with a depth-first visit order.
// ----------------------------------------------------------------------------
// An add-edge request sets one bit of the adjacency matrix; edges with an
// endpoint at or above the vertex count are dropped. A traverse request
// clears the visited marks and emits every live vertex once, in depth-first
// order, with the final one flagged by last_in_order. Each vertex is found
// by one successful search and later costs one failed neighbor search and a
// stack reload. A neighbor search is a registered read of the adjacency
// memory followed by the two-stage lowest-bit encoder; a search for a new
// start vertex uses the encoder alone. The matrix is cleared at reset
// through per-row valid bits, so no clearing pass is needed and the block
// takes requests right after reset. The request side is ready only while
// the sequencer idles; the vertex count is written through the csr port and
// must only change between requests.
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_order
   import amdfs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   amdfs_req_if.sink               req_ch,
   amdfs_rsp_if.source             rsp_ch,
   input  wire logic               csr_write_enable,
   input  wire logic [COUNT_W-1:0] csr_write_data
);

   // ------------------------------------------------------------------------
   // Microcode. Each step has one control word: the datapath action, whether
   // it may emit a vertex, the jump condition and two jump targets.
   // ------------------------------------------------------------------------
   localparam int STEP_W = 4;

   localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
   localparam logic [STEP_W-1:0] ST_INIT       = 4'd1;
   localparam logic [STEP_W-1:0] ST_OUTER_SCAN = 4'd2;
   localparam logic [STEP_W-1:0] ST_OUTER_PICK = 4'd3;
   localparam logic [STEP_W-1:0] ST_INNER_SCAN = 4'd4;
   localparam logic [STEP_W-1:0] ST_INNER_PICK = 4'd5;
   localparam logic [STEP_W-1:0] ST_FINISH     = 4'd6;
   localparam logic [STEP_W-1:0] ST_EDGE_WR    = 4'd7;
   localparam logic [STEP_W-1:0] ST_POP_LD     = 4'd8;

   localparam logic [3:0] A_IDLE       = 4'd0;
   localparam logic [3:0] A_INIT       = 4'd1;
   localparam logic [3:0] A_SCAN_OUTER = 4'd2;
   localparam logic [3:0] A_SCAN_INNER = 4'd3;
   localparam logic [3:0] A_PICK       = 4'd4;
   localparam logic [3:0] A_PICK_POP   = 4'd5;
   localparam logic [3:0] A_FINISH     = 4'd6;
   localparam logic [3:0] A_EDGE       = 4'd7;
   localparam logic [3:0] A_RELOAD     = 4'd8;

   localparam logic [1:0] C_ALWAYS = 2'd0;
   localparam logic [1:0] C_REQ    = 2'd1;
   localparam logic [1:0] C_FOUND  = 2'd2;
   localparam logic [1:0] C_EMPTY  = 2'd3;

   typedef struct packed {
      logic [3:0]        act;
      logic              emit;
      logic [1:0]        cond;
      logic [STEP_W-1:0] t_true;
      logic [STEP_W-1:0] t_false;
   } ucode_type;

   // The program. On a request, a traverse goes to t_true and an add-edge to
   // t_false. A found candidate goes to t_true. An empty stack goes to t_true.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      unique case (step)
         ST_IDLE:       w = '{A_IDLE,       1'b0, C_REQ,    ST_INIT,       ST_EDGE_WR};
         ST_INIT:       w = '{A_INIT,       1'b0, C_ALWAYS, ST_OUTER_SCAN, ST_OUTER_SCAN};
         ST_OUTER_SCAN: w = '{A_SCAN_OUTER, 1'b0, C_ALWAYS, ST_OUTER_PICK, ST_OUTER_PICK};
         ST_OUTER_PICK: w = '{A_PICK,       1'b1, C_FOUND,  ST_INNER_SCAN, ST_FINISH};
         ST_INNER_SCAN: w = '{A_SCAN_INNER, 1'b0, C_ALWAYS, ST_INNER_PICK, ST_INNER_PICK};
         ST_INNER_PICK: w = '{A_PICK_POP,   1'b1, C_FOUND,  ST_INNER_SCAN, ST_POP_LD};
         ST_FINISH:     w = '{A_FINISH,     1'b1, C_ALWAYS, ST_IDLE,       ST_IDLE};
         ST_EDGE_WR:    w = '{A_EDGE,       1'b0, C_ALWAYS, ST_IDLE,       ST_IDLE};
         ST_POP_LD:     w = '{A_RELOAD,     1'b0, C_EMPTY,  ST_OUTER_SCAN, ST_INNER_SCAN};
         default:       w = '{A_IDLE,       1'b0, C_ALWAYS, ST_IDLE,       ST_IDLE};
      endcase
      return w;
   endfunction

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_VERTICES);

   // ------------------------------------------------------------------------
   // State.
   // ------------------------------------------------------------------------
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [ROW_W-1:0]    visited_ff, visited_in;
   logic [COUNT_W-1:0]  depth_ff, depth_in;
   logic                pending_valid_ff, pending_valid_in;
   logic [VERTEX_W-1:0] pending_vertex_ff, pending_vertex_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [VERTEX_W-1:0] from_ff, to_ff;

   // Adjacency memory with one valid bit per row; an invalid row reads as no
   // edges, which is how reset clears the matrix.
   logic [ROW_W-1:0]        adj_mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [ROW_W-1:0]        adj_rd_ff;
   logic                    adj_rd_valid_ff;

   // Path stack memory; entries are written before they are read.
   logic [VERTEX_W-1:0] stack_mem [MAX_VERTICES];
   logic [VERTEX_W-1:0] stack_rd_ff;

   ucode_type        word;
   lowbit_type       lb;
   logic             accept;
   logic             stall;
   logic             out_busy;
   logic [COUNT_W-1:0] live_count;
   logic [ROW_W-1:0] live_mask;
   logic [ROW_W-1:0] row_eff;
   logic [ROW_W-1:0] cand;
   logic             lb_load;
   logic             hit;
   logic             push;
   logic             pop;
   logic             adj_re;
   logic [ADDR_W-1:0] adj_ra;
   logic             adj_we;
   logic [COUNT_W-1:0] pop_addr;

   assign word = ucode_rom(step_ff);

   // A count above the memory size acts as the memory size.
   assign live_count = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;

   always_comb begin
      for (int i = 0; i < ROW_W; i++) begin
         live_mask[i] = (COUNT_W'(i) < live_count);
      end
   end

   assign row_eff = adj_rd_valid_ff ? adj_rd_ff : '0;

   // Outer searches look for the lowest unvisited live vertex, inner searches
   // for the lowest unvisited live neighbor of the vertex just read.
   assign cand    = (word.act == A_SCAN_INNER) ? (row_eff & live_mask & ~visited_ff)
                                               : (live_mask & ~visited_ff);
   assign lb_load = (word.act == A_SCAN_INNER) || (word.act == A_SCAN_OUTER);

   amdfs_lowbit u_lowbit (
      .clock  (clock),
      .load   (lb_load),
      .cand   (cand),
      .result (lb)
   );

   assign req_ch.ready = (step_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // A vertex is held back until the next one is found, so that the final one can be flagged.
   // Pushing the held vertex out waits while the output register is taken.
   assign out_busy = rsp_valid_ff && !rsp_ch.ready;
   assign stall    = word.emit && pending_valid_ff && out_busy;

   assign hit  = !stall && lb.found &&
                 ((word.act == A_PICK) || (word.act == A_PICK_POP));
   assign push = hit && (depth_ff < MAX_COUNT);
   assign pop  = !stall && !lb.found && (word.act == A_PICK_POP);

   // After a pop the new top of stack sits two below the old depth.
   assign pop_addr = depth_ff - COUNT_W'(2);

   // ------------------------------------------------------------------------
   // Sequencer and datapath.
   // ------------------------------------------------------------------------
   always_comb begin
      step_in           = step_ff;
      visited_in        = visited_ff;
      depth_in          = depth_ff;
      pending_valid_in  = pending_valid_ff;
      pending_vertex_in = pending_vertex_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_vertex_in     = rsp_vertex_ff;
      rsp_last_in       = rsp_last_ff;

      if (!stall) begin
         unique case (word.cond)
            C_ALWAYS: step_in = word.t_true;
            C_REQ: begin
               if (accept) begin
                  step_in = (req_ch.operation == OP_TRAVERSE) ? word.t_true
                                                              : word.t_false;
               end
            end
            C_FOUND: step_in = lb.found ? word.t_true : word.t_false;
            C_EMPTY: step_in = (depth_ff == '0) ? word.t_true : word.t_false;
         endcase
      end

      if (word.act == A_INIT) begin
         visited_in       = '0;
         depth_in         = '0;
         pending_valid_in = 1'b0;
      end

      if (hit) begin
         visited_in = visited_ff | (ROW_W'(1) << lb.index);
         if (pending_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = pending_vertex_ff;
            rsp_last_in   = 1'b0;
         end
         pending_valid_in  = 1'b1;
         pending_vertex_in = lb.index;
      end

      if (push) begin
         depth_in = depth_ff + COUNT_W'(1);
      end

      if (pop) begin
         depth_in = depth_ff - COUNT_W'(1);
      end

      // The last held vertex leaves with the flag set.
      if ((word.act == A_FINISH) && !stall && pending_valid_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_vertex_in    = pending_vertex_ff;
         rsp_last_in      = 1'b1;
         pending_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= ST_IDLE;
         count_ff         <= '0;
         depth_ff         <= '0;
         pending_valid_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         step_ff          <= step_in;
         depth_ff         <= depth_in;
         pending_valid_ff <= pending_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      visited_ff        <= visited_in;
      pending_vertex_ff <= pending_vertex_in;
      rsp_vertex_ff     <= rsp_vertex_in;
      rsp_last_ff       <= rsp_last_in;
      if (accept) begin
         from_ff <= req_ch.from_vertex;
         to_ff   <= req_ch.to_vertex;
      end
   end

   // ------------------------------------------------------------------------
   // Adjacency memory. The idle step keeps reading the row of the request's
   // source vertex so that an add-edge can write the merged row next cycle.
   // A pick reads the row of the vertex it found; a reload reads the row of
   // the vertex that is now on top of the stack.
   // ------------------------------------------------------------------------
   always_comb begin
      adj_re = 1'b0;
      adj_ra = '0;
      unique case (word.act)
         A_IDLE: begin
            adj_re = 1'b1;
            adj_ra = req_ch.from_vertex[ADDR_W-1:0];
         end
         A_PICK, A_PICK_POP: begin
            adj_re = !stall;
            adj_ra = lb.index[ADDR_W-1:0];
         end
         A_RELOAD: begin
            adj_re = 1'b1;
            adj_ra = stack_rd_ff[ADDR_W-1:0];
         end
         default: begin
            adj_re = 1'b0;
            adj_ra = '0;
         end
      endcase
   end

   assign adj_we = (word.act == A_EDGE) &&
                   (COUNT_W'(from_ff) < live_count) && (COUNT_W'(to_ff) < live_count);

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem[from_ff[ADDR_W-1:0]] <= row_eff | (ROW_W'(1) << to_ff);
      end
      if (adj_re) begin
         adj_rd_ff <= adj_mem[adj_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff    <= '0;
         adj_rd_valid_ff <= 1'b0;
      end else begin
         if (adj_we) begin
            row_valid_ff[from_ff[ADDR_W-1:0]] <= 1'b1;
         end
         if (adj_re) begin
            adj_rd_valid_ff <= row_valid_ff[adj_ra];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Path stack. A push writes at the current depth; a pop reads the entry
   // that becomes the new top.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (push) begin
         stack_mem[depth_ff[ADDR_W-1:0]] <= lb.index;
      end
      if (pop) begin
         stack_rd_ff <= stack_mem[pop_addr[ADDR_W-1:0]];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.visited_vertex = rsp_vertex_ff;
   assign rsp_ch.last_in_order  = rsp_last_ff;

endmodule
`default_nettype wire

### rtl/amdfs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// amdfs_checker
// Port-level checks of the depth-first order block, bound to the top level.
// ----------------------------------------------------------------------------
module amdfs_checker
   import amdfs_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [VERTEX_W-1:0] rsp_vertex,
   input wire logic                rsp_last
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A request is never taken while a traversal is still emitting.
   a_busy_while_emitting: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !req_ready)
      else $error("request ready in the middle of a traversal");

   // Every accepted request takes the sequencer out of idle, so ready is low in the cycle after it.
   a_accept_drops_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after an accepted request");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_vertex) && $stable(rsp_last)))
      else $error("stalled response changed");

endmodule

bind adjacency_matrix_dfs_order amdfs_checker u_amdfs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_vertex (rsp_ch.visited_vertex),
   .rsp_last   (rsp_ch.last_in_order)
);
`default_nettype wire

### test/tb_adjacency_matrix_dfs_order.sv
// ----------------------------------------------------------------------------
// tb_adjacency_matrix_dfs_order
// Self-checking bench for the adjacency matrix depth-first order block.
// ----------------------------------------------------------------------------
// Builds graphs with add-edge requests and runs traverse requests against a
// behavioral copy of the matrix. The copy works out the depth-first visit
// order that each traverse request must return, and a scoreboard compares
// every response with it. The vertex count is changed between phases while
// the block is idle. The sender works in bursts, and the receiver follows its
// own stall pattern, which includes one long hold.
// ----------------------------------------------------------------------------
module tb_adjacency_matrix_dfs_order
   import amdfs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off here if the block stops making progress.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Idle cycles after the last response before the count is rewritten or the
   // run ends. An add-edge request can still be in flight while nothing is
   // expected.
   localparam int SETTLE_CYCLES = 12;
   // Length of the single long receiver hold.
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int RANDOM_REQUESTS = 500;

   // One expected response: a vertex and whether it ends the traversal.
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } visit_type;

   // Receiver stall modes, each kept for a random window of cycles.
   typedef enum logic [1:0] {
      TAKE_ALL,
      TAKE_HALF,
      TAKE_RARE,
      TAKE_ALTERNATE
   } take_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a behavioral copy of the adjacency matrix and vertex count,
   // plus the queue of visits still owed by the block.
   // -------------------------------------------------------------------------
   class dfs_scoreboard;
      logic [ROW_W-1:0] arc_rows [MAX_VERTICES];
      logic [COUNT_W-1:0] vertex_count;
      visit_type owed_visits [$];
      int errors;

      function new();
         foreach (arc_rows[i]) arc_rows[i] = '0;
         vertex_count = '0;
         errors = 0;
      endfunction

      function void set_count(logic [COUNT_W-1:0] value);
         vertex_count = value;
      endfunction

      // A count above the matrix size behaves as the full matrix.
      function int live_count();
         return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
      endfunction

      function int owed();
         return owed_visits.size();
      endfunction

      // Walks the graph the way the block must: start vertices in ascending
      // order, neighbors in ascending order, edges to vertices at or above
      // the current count ignored.
      function void predict_traversal();
         int n;
         logic [ROW_W-1:0] live_mask;
         logic [ROW_W-1:0] seen;
         logic [ROW_W-1:0] cand;
         int path [MAX_VERTICES];
         int depth;
         int order [MAX_VERTICES];
         int visits;
         int next_v;
         visit_type item;
         n = live_count();
         live_mask = (n >= ROW_W) ? {ROW_W{1'b1}} : ((ROW_W'(1) << n) - ROW_W'(1));
         seen = '0;
         visits = 0;
         for (int s = 0; s < n; s++) begin
            if (seen[s]) continue;
            seen[s] = 1'b1;
            order[visits++] = s;
            path[0] = s;
            depth = 1;
            while (depth > 0) begin
               cand = arc_rows[path[depth-1]] & live_mask & ~seen;
               if (cand == '0) begin
                  depth--;
               end else begin
                  next_v = 0;
                  while (!cand[next_v]) next_v++;
                  seen[next_v] = 1'b1;
                  order[visits++] = next_v;
                  path[depth++] = next_v;
               end
            end
         end
         for (int i = 0; i < visits; i++) begin
            item.vertex = VERTEX_W'(order[i]);
            item.last = (i == visits - 1);
            owed_visits.push_back(item);
         end
      endfunction

      // Notes an accepted request. Returns 0 for an edge that the block drops.
      function bit note_request(logic op, logic [VERTEX_W-1:0] src,
                                logic [VERTEX_W-1:0] dst);
         if (op == OP_TRAVERSE) begin
            predict_traversal();
            return 1'b1;
         end
         if (src < live_count() && dst < live_count()) begin
            arc_rows[src][dst] = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void check_visit(logic [VERTEX_W-1:0] vertex, logic last);
         visit_type want;
         if (owed_visits.size() == 0) begin
            errors++;
            if (errors <= 100)
               $display("%0t: unexpected response: expected none, actual vertex %0d last %0b",
                        $time, vertex, last);
            return;
         end
         want = owed_visits.pop_front();
         if (vertex !== want.vertex) begin
            errors++;
            if (errors <= 100)
               $display("%0t: visited_vertex mismatch: expected %0d, actual %0d",
                        $time, want.vertex, vertex);
         end
         if (last !== want.last) begin
            errors++;
            if (errors <= 100)
               $display("%0t: last_in_order mismatch: expected %0b, actual %0b",
                        $time, want.last, last);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the signals driven into the block. Everything starts at
   // a known value; the bench changes them with nonblocking assignments at
   // the rising edge only.
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_op    = OP_ADD_EDGE;
   logic [VERTEX_W-1:0] req_from  = '0;
   logic [VERTEX_W-1:0] req_to    = '0;
   logic                rsp_take  = 1'b0;
   logic                csr_we    = 1'b0;
   logic [COUNT_W-1:0]  csr_data  = '0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   amdfs_req_if req_bus ();
   amdfs_rsp_if rsp_bus ();

   assign req_bus.valid       = req_valid;
   assign req_bus.operation   = req_op;
   assign req_bus.from_vertex = req_from;
   assign req_bus.to_vertex   = req_to;
   assign rsp_bus.ready       = rsp_take;

   adjacency_matrix_dfs_order dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_we),
      .csr_write_data   (csr_data)
   );

   dfs_scoreboard sb;

   // -------------------------------------------------------------------------
   // Watchdog. A correct run stays far below this limit even if every
   // traversal covered all 64 vertices under the slowest receiver pattern.
   // -------------------------------------------------------------------------
   int unsigned cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. The ready pattern changes mode after each random window, from
   // taking every response to taking few of them. Once in the run the main
   // sequence asks for a long hold; this process counts it out itself, so the
   // block fills up while the sender keeps offering requests.
   // -------------------------------------------------------------------------
   logic          long_hold_req   = 1'b0;
   logic          long_hold_taken = 1'b0;
   int            hold_left       = 0;
   int            window_left     = 0;
   take_mode_type take_mode       = TAKE_ALL;

   always @(posedge clock) begin
      if (long_hold_req && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_take <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_take <= 1'b0;
      end else begin
         if (window_left == 0) begin
            window_left <= $urandom_range(80, 20);
            take_mode <= take_mode_type'($urandom_range(3, 0));
         end else begin
            window_left <= window_left - 1;
         end
         case (take_mode)
            TAKE_ALL:       rsp_take <= 1'b1;
            TAKE_HALF:      rsp_take <= 1'($urandom_range(1, 0));
            TAKE_RARE:      rsp_take <= ($urandom_range(4, 0) == 0);
            TAKE_ALTERNATE: rsp_take <= ~rsp_take;
         endcase
      end
   end

   // Response monitor. Values read here are those from just before the edge,
   // since the block and the bench both update through nonblocking
   // assignments.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_take)
         sb.check_visit(rsp_bus.visited_vertex, rsp_bus.last_in_order);
   end

   // -------------------------------------------------------------------------
   // Sender. Requests go out in bursts of random length with random gaps in
   // between; now and then a burst is long enough to leave the block no idle
   // cycle on the request side.
   // -------------------------------------------------------------------------
   int burst_left = 0;
   int useful_requests = 0;

   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                   : $urandom_range(12, 0);
      end
   endtask

   // Offers one request and holds it until the block accepts it. The caller
   // is always just past a rising edge.
   task automatic send_request(logic op, logic [VERTEX_W-1:0] src,
                               logic [VERTEX_W-1:0] dst);
      req_valid <= 1'b1;
      req_op <= op;
      req_from <= src;
      req_to <= dst;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (sb.note_request(op, src, dst)) useful_requests++;
      pace();
   endtask

   task automatic add_arc(int src, int dst);
      send_request(OP_ADD_EDGE, VERTEX_W'(src), VERTEX_W'(dst));
   endtask

   // The address fields mean nothing to a traverse request, so they carry
   // random bits.
   task automatic traverse();
      send_request(OP_TRAVERSE, VERTEX_W'($urandom), VERTEX_W'($urandom));
   endtask

   // Stops the sender and waits until every owed response has arrived and
   // any trailing add-edge request has finished.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.owed() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called right after reset or settle, so the block is idle.
   task automatic write_count(int value);
      csr_we <= 1'b1;
      csr_data <= COUNT_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_count(COUNT_W'(value));
   endtask

   // One well-formed sequence: a burst of add-edge requests, mostly inside
   // the live vertex range, then usually a traverse request. Some sequences
   // lay down a chain of edges so that the path stack grows deep.
   task automatic run_sequence(int n);
      int arcs;
      int base;
      int run;
      if (n > 1 && $urandom_range(4, 0) == 0) begin
         base = $urandom_range(n - 2, 0);
         run = n - 1 - base;
         if (run > 24) run = $urandom_range(24, 4);
         for (int i = 0; i < run; i++) add_arc(base + i, base + i + 1);
      end else begin
         arcs = $urandom_range(12, 0);
         repeat (arcs) begin
            // Some edges are pure noise and may fall outside the live range.
            if (n == 0 || $urandom_range(6, 0) == 0)
               add_arc($urandom_range(63, 0), $urandom_range(63, 0));
            else
               add_arc($urandom_range(n - 1, 0), $urandom_range(n - 1, 0));
         end
      end
      if ($urandom_range(9, 0) != 0) traverse();
   endtask

   // Most phases keep the graph small so that traversals stay short; a few
   // use the whole matrix or a count above it.
   function automatic int pick_count();
      int pick;
      pick = $urandom_range(19, 0);
      if (pick == 0) return MAX_VERTICES;
      if (pick == 1) return $urandom_range(127, MAX_VERTICES + 1);
      if (pick == 2) return $urandom_range(1, 0);
      if (pick <= 5) return $urandom_range(MAX_VERTICES - 1, 17);
      return $urandom_range(16, 2);
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int phase;
      int count;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty graph: with a count of zero every edge is dropped and a
      // traversal returns nothing.
      write_count(0);
      add_arc(0, 1);
      traverse();
      settle();

      // Four vertices: a back edge to a visited vertex, a self loop, a second
      // branch from the root, and edges that reach past the count.
      write_count(4);
      add_arc(0, 1);
      add_arc(1, 3);
      add_arc(3, 0);
      add_arc(2, 2);
      add_arc(0, 2);
      add_arc(1, 5);
      add_arc(63, 0);
      traverse();
      settle();

      // A count above the maximum acts as the full matrix; edges at the top
      // vertex index.
      write_count(127);
      add_arc(0, 63);
      add_arc(63, 62);
      add_arc(63, 63);
      add_arc(62, 0);
      traverse();
      settle();

      // Count lowered after edges were added: edges beyond the count vanish
      // from the walk.
      write_count(2);
      traverse();
      settle();

      // A single vertex is both first and last.
      write_count(1);
      add_arc(0, 0);
      traverse();
      settle();

      write_count(MAX_VERTICES);
      traverse();

      // Random phases, each with its own vertex count. Phase 2 uses the full
      // matrix and holds the receiver off for a long stretch while the
      // sender keeps offering requests. Every phase boundary pauses the
      // sender until all owed responses have arrived.
      useful_requests = 0;
      phase = 0;
      while (useful_requests < RANDOM_REQUESTS) begin
         settle();
         count = (phase == 2) ? MAX_VERTICES : pick_count();
         write_count(count);
         if (phase == 2) begin
            long_hold_req <= 1'b1;
            traverse();
         end
         repeat ($urandom_range(4, 1)) run_sequence(sb.live_count());
         phase++;
      end

      settle();
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
